[sv/sdram_controller_config_regs_assert.svh]
// assertion helpers for the sdram config register block
`ifndef SDRAM_CONTROLLER_CONFIG_REGS_ASSERT_SVH
`define SDRAM_CONTROLLER_CONFIG_REGS_ASSERT_SVH

// clocked check, off while reset is held
`define SDCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also runs during reset
`define SDCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/sdcr_pkg.sv]
`default_nettype none

package sdcr_pkg;

  typedef enum logic [2:0] {
    SelRevid    = 3'd0,
    SelCfg      = 3'd1,
    SelRefresh  = 3'd2,
    SelTim1     = 3'd3,
    SelTim2     = 3'd4,
    SelCfg2     = 3'd5,
    SelPriority = 3'd6
  } sel_e;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  localparam logic [3:0] WriteSize = 4'd4;

  localparam logic [31:0] RevisionWord  = 32'h4033_131f;
  localparam logic [31:0] CfgReset      = 32'h0001_0620;
  localparam logic [31:0] RefreshReset  = 32'h0000_04e2;
  localparam logic [31:0] Tim1Reset     = 32'h14d9_3a90;
  localparam logic [31:0] Tim2Reset     = 32'h700a_0007;
  localparam logic [31:0] Cfg2Reset     = 32'h0000_0000;
  localparam logic [7:0]  PriorityReset = 8'hff;

  localparam int unsigned CfgBootBit   = 23;
  localparam int unsigned CfgEnableBit = 16;
  localparam int unsigned CfgTimeBit   = 15;

  localparam logic [31:0] CfgLegalBits  = 32'h0681_CE77;
  localparam logic [31:0] CfgGuarded    = 32'h0601_0000;
  localparam logic [31:0] CfgCasField   = 32'h0000_0E00;
  localparam logic [31:0] RfcLegalBits  = 32'hC080_FFFF;
  localparam logic [31:0] Tim2LegalBits = 32'h787F_001F;
  localparam logic [31:0] Cfg2LegalBits = 32'h0007_0007;
  localparam logic [31:0] PrioLegalBits = 32'h0000_00FF;
  localparam logic [15:0] RateFloor     = 16'h0100;

  localparam int unsigned InDataW   = 72;
  localparam int unsigned InUserW   = 4;
  localparam int unsigned OutDataW  = 72;

endpackage

`default_nettype wire

[sv/sdram_controller_config_regs.sv]
// sdram controller configuration register block
// input stream: one bus access per request; tuser carries the command and
// register select, tdata the write value, access size and commit flag
// output stream: one result per request with ok, read data, the sdram
// enable bit and the init counter as they stand after the access
// a request is registered on entry, then decoded, checked and applied to the
// register file once the output stage can advance, while the result is registered
// throughput is one request per cycle unless the receiver stalls; the register
// file update is the only loop
// when the receiver stalls, the result holds and one more request waits in
// the input register; after that tready drops until the result is taken
// reset clears both valid flags and loads the documented register defaults
// probe writes (commit low) answer legality without changing anything
`default_nettype none

`include "sdram_controller_config_regs_assert.svh"

module sdram_controller_config_regs
  import sdcr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // write_value[63:0], access_size[67:64], commit[68], zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // cmd[0], reg_select[3:1]
  input  wire logic [InUserW-1:0]  s_axis_tuser_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // ok[0], read_data[32:1], sdram_enabled[33], init_count[65:34], zero pad
  output      logic [OutDataW-1:0] m_axis_tdata_o
);

  logic        in_vld_q;
  logic        in_cmd_q;
  logic [2:0]  in_sel_q;
  logic [63:0] in_val_q;
  logic [3:0]  in_size_q;
  logic        in_commit_q;

  logic        out_vld_q;
  logic        out_ok_q;
  logic [31:0] out_data_q;

  logic [31:0] cfg_q, cfg_d;
  logic [31:0] rfc_q, rfc_d;
  logic [31:0] tim1_q, tim1_d;
  logic [31:0] tim2_q, tim2_d;
  logic [31:0] cfg2_q, cfg2_d;
  logic [7:0]  prio_q, prio_d;
  logic [31:0] init_q, init_d;

  logic        advance;
  logic        ok_d;
  logic [31:0] data_d;
  logic [31:0] v;
  logic        shape_ok;
  logic        apply;
  logic        cfg_legal;
  logic        cfg2_legal;
  logic [31:0] cfg_next;
  logic [15:0] rate;
  logic [2:0]  cas, banks, page, arr, rows;

  assign advance         = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || advance;

  always_comb begin
    v        = in_val_q[31:0];
    shape_ok = (in_size_q == WriteSize) && (in_val_q[63:32] == 32'd0);
    apply    = in_vld_q && advance && in_commit_q && (in_cmd_q == CmdWrite) && shape_ok;

    cas   = v[11:9];
    banks = v[6:4];
    page  = v[2:0];
    cfg_legal = ((v & ~CfgLegalBits) == 32'd0) && (cas >= 3'd2) && (cas <= 3'd3) &&
                (banks <= 3'd2) && (page <= 3'd3);
    arr  = v[18:16];
    rows = v[2:0];
    cfg2_legal = ((v & ~Cfg2LegalBits) == 32'd0) && (arr != 3'd3) && (arr != 3'd4) &&
                 (arr != 3'd7) && (rows <= 3'd5);

    cfg_next = (v & ~CfgGuarded) | (cfg_q & CfgGuarded);
    if (cfg_q[CfgBootBit]) begin
      cfg_next = (cfg_next & ~CfgGuarded) | (v & CfgGuarded);
    end
    if (!v[CfgTimeBit]) begin
      cfg_next = (cfg_next & ~CfgCasField) | (cfg_q & CfgCasField);
    end

    rate = v[15:0];
    if (rate < RateFloor) begin
      rate = {8'd0, tim1_q[31:25], 1'b0};
    end

    cfg_d  = cfg_q;
    rfc_d  = rfc_q;
    tim1_d = tim1_q;
    tim2_d = tim2_q;
    cfg2_d = cfg2_q;
    prio_d = prio_q;
    init_d = init_q;
    ok_d   = 1'b0;
    data_d = 32'd0;

    if (in_cmd_q == CmdRead) begin
      ok_d = 1'b1;
      case (sel_e'(in_sel_q))
        SelRevid:    data_d = RevisionWord;
        SelCfg:      data_d = cfg_q;
        SelRefresh:  data_d = rfc_q;
        SelTim1:     data_d = tim1_q;
        SelTim2:     data_d = tim2_q;
        SelCfg2:     data_d = cfg2_q;
        SelPriority: data_d = {24'd0, prio_q};
        default: begin
          ok_d   = 1'b0;
          data_d = 32'd0;
        end
      endcase
    end else if (shape_ok) begin
      case (sel_e'(in_sel_q))
        SelCfg: begin
          ok_d = cfg_legal;
          if (apply && cfg_legal) begin
            cfg_d  = cfg_next;
            init_d = init_q + 32'd1;
          end
        end
        SelRefresh: begin
          ok_d = ((v & ~RfcLegalBits) == 32'd0);
          if (apply && ok_d) begin
            rfc_d = {v[31:16], rate};
          end
        end
        SelTim1: begin
          ok_d = (v[2:0] == 3'd0) && (v[15:11] >= {2'd0, v[21:19]});
          if (apply && ok_d && cfg_q[CfgTimeBit]) begin
            tim1_d = v;
          end
        end
        SelTim2: begin
          ok_d = ((v & ~Tim2LegalBits) == 32'd0);
          if (apply && ok_d && cfg_q[CfgTimeBit]) begin
            tim2_d = v;
          end
        end
        SelCfg2: begin
          ok_d = cfg2_legal;
          if (apply && cfg2_legal) begin
            cfg2_d = v;
            init_d = init_q + 32'd1;
          end
        end
        SelPriority: begin
          ok_d = ((v & ~PrioLegalBits) == 32'd0);
          if (apply && ok_d) begin
            prio_d = v[7:0];
          end
        end
        default: ok_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cfg_q     <= CfgReset;
      rfc_q     <= RefreshReset;
      tim1_q    <= Tim1Reset;
      tim2_q    <= Tim2Reset;
      cfg2_q    <= Cfg2Reset;
      prio_q    <= PriorityReset;
      init_q    <= 32'd0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      cfg_q  <= cfg_d;
      rfc_q  <= rfc_d;
      tim1_q <= tim1_d;
      tim2_q <= tim2_d;
      cfg2_q <= cfg2_d;
      prio_q <= prio_d;
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q    <= s_axis_tuser_i[0];
      in_sel_q    <= s_axis_tuser_i[3:1];
      in_val_q    <= s_axis_tdata_i[63:0];
      in_size_q   <= s_axis_tdata_i[67:64];
      in_commit_q <= s_axis_tdata_i[68];
    end
    if (advance && in_vld_q) begin
      out_ok_q   <= ok_d;
      out_data_q <= data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, init_q, cfg_q[CfgEnableBit], out_data_q, out_ok_q};

  `SDCR_ASSERT(a_init_step, 1'b1 |=> (init_q == $past(init_q) || init_q == $past(init_q) + 32'd1), "init counter moved by more than one")
  `SDCR_ASSERT(a_tim_locked, !cfg_q[CfgTimeBit] |=> ($stable(tim1_q) && $stable(tim2_q)), "timing register changed while locked")
  `SDCR_ASSERT(a_guard_locked, !cfg_q[CfgBootBit] |=> $stable(cfg_q[CfgEnableBit]), "sdram enable changed without boot unlock")
  `SDCR_ASSERT_ALWAYS(a_stall_only, !s_axis_tready_o |-> (in_vld_q && m_axis_tvalid_o && !m_axis_tready_i), "input stalled without a blocked result")

endmodule

`default_nettype wire
